### rtl/stc_pkg.sv
package stc_pkg;

  // Fixed-point format of every internal term: hundredths of a degree, Q.16
  localparam int FRAC_BITS = 16;

  // Register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_POWER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_OFFSET = 3'd6;

  typedef struct packed {
    logic        [9:0]  linear;
    logic signed [10:0] offset;
    logic        [9:0]  exp_gain;
    logic        [9:0]  exp_rate;
    logic        [9:0]  exp_power;
    logic signed [10:0] log_gain;
    logic signed [10:0] log_offset;
  } coef_t;

  localparam coef_t COEF_RESET = '{
    linear:     10'd33,
    offset:     11'sd0,
    exp_gain:   10'd4,
    exp_rate:   10'd100,
    exp_power:  10'd100,
    log_gain:   11'sd0,
    log_offset: 11'sd0
  };

  // Sub-block latencies in register stages
  localparam int EXP_LAT = 27;
  localparam int LOG_LAT = 21;

  // ln(2) and log10(2) scaled
  localparam longint LN2_Q30     = 744261118;
  localparam longint LOG10_2_Q30 = 323228497;
  localparam int     LN2_Q       = int'((LN2_Q30 + (64'd1 << (29 - FRAC_BITS)))
                                       >> (30 - FRAC_BITS));

  // Exact reciprocals: floor(x / d) = (x * M) >> S over the operand range used
  localparam logic [25:0] RCP100_A   = 26'd42949673;   // x < 2^25, S = 32
  localparam logic [23:0] RCP100_B   = 24'd10737419;   // x < 2^23, S = 30
  localparam logic [27:0] RCP100_C   = 28'd171798692;  // x < 2^27, S = 34
  localparam logic [28:0] RCP78125_A = 29'd450359963;  // x < 2^28, S = 45
  localparam logic [26:0] RCP78125_B = 27'd112589991;  // x < 2^26, S = 43
  localparam logic [21:0] RCP_LN2    = 22'd3025558;    // x < 2^21, S = 37

  // Horner step divisor k: t / k = (t * horner_mul(k)) >> horner_shift(k)
  function automatic logic [18:0] horner_mul(input int k);
    logic [18:0] m;
    case (k)
      3:       m = 19'd349526;
      5:       m = 19'd419431;
      6:       m = 19'd349526;
      7:       m = 19'd299594;
      default: m = 19'd1;
    endcase
    return m;
  endfunction

  function automatic int horner_shift(input int k);
    int s;
    case (k)
      2:       s = 1;
      3:       s = 20;
      4:       s = 2;
      5:       s = 21;
      6:       s = 21;
      7:       s = 21;
      8:       s = 3;
      default: s = 0;
    endcase
    return s;
  endfunction

endpackage

### rtl/stc_if.sv
interface stc_in_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] sky_temp;
  logic signed [14:0] ambient_temp;

  modport source (output valid, output sky_temp, output ambient_temp, input ready);
  modport sink   (input valid, input sky_temp, input ambient_temp, output ready);
endinterface

interface stc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] corrected_temp;
  logic               saturated;

  modport source (output valid, output corrected_temp, output saturated, input ready);
  modport sink   (input valid, input corrected_temp, input saturated, output ready);
endinterface

### rtl/sky_temperature_correction.sv
// Sky temperature correction for an infrared cloud sensor.
//
// Requests arrive on req_i (sky_temp, ambient_temp, hundredths of a degree C)
// and results leave on res_o (corrected_temp, saturated). A request is taken
// when valid and ready are both high; one result comes back per request, in
// order.
// The deepest path is the exp() unit: argument scaling, range reduction and
// an 8-term Horner series at two stages per term.
// Throughput: one request per cycle. The whole pipe advances together; it
// only holds when res_o carries a valid result that is not taken, and then
// req_i.ready is low until the result leaves. No request is dropped or
// duplicated by a stall.
// Coefficients are written through cfg_we_i / cfg_idx_i / cfg_data_i with no
// handshake; writes to an index past the last register are ignored. Write
// them only while the pipe is empty.
// Reset clears the pipeline valid bits and loads the default coefficients.
module sky_temperature_correction (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  stc_in_if.sink                              req_i,
  stc_out_if.source                           res_o,
  input  logic                                cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int PIPE_DEPTH = stc_pkg::EXP_LAT + 3;
  // w1 is made at stage 7 and meets the log term at stage 1 + LOG_LAT
  localparam int D1 = 1 + stc_pkg::LOG_LAT - 7;
  // w2 is made at stage 1 + LOG_LAT + 1 and meets exp at stage 1 + EXP_LAT
  localparam int D2 = stc_pkg::EXP_LAT - stc_pkg::LOG_LAT - 1;

  // ---------------- coefficient registers ----------------
  stc_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= stc_pkg::COEF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stc_pkg::REG_LINEAR:     coef_q.linear     <= cfg_data_i[9:0];
        stc_pkg::REG_OFFSET:     coef_q.offset     <= $signed(cfg_data_i);
        stc_pkg::REG_EXP_GAIN:   coef_q.exp_gain   <= cfg_data_i[9:0];
        stc_pkg::REG_EXP_RATE:   coef_q.exp_rate   <= cfg_data_i[9:0];
        stc_pkg::REG_EXP_POWER:  coef_q.exp_power  <= cfg_data_i[9:0];
        stc_pkg::REG_LOG_GAIN:   coef_q.log_gain   <= $signed(cfg_data_i);
        stc_pkg::REG_LOG_OFFSET: coef_q.log_offset <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  // every stage moves unless the output slot is full and stalled
  assign en          = ~vld_q[PIPE_DEPTH-1] | res_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], req_i.valid};
    end
  end

  // ---------------- stage 1: capture, d = ta - 10*offset ----------------
  logic signed [16:0] ts1_q;
  logic signed [14:0] ta1_q;
  logic signed [15:0] dh1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ts1_q <= req_i.sky_temp;
      ta1_q <= req_i.ambient_temp;
      dh1_q <= 16'(req_i.ambient_temp) - 16'(15'(coef_q.offset) * 15'sd10);
    end
  end

  // ---------------- linear term, stages 2..6 ----------------
  // round(linear * d * 2^16 / 100) split as a = 100*qa + ra
  logic [24:0]        a2_q, a3_q;
  logic [18:0]        qa3_q, qa4_q, qa5_q;
  logic [6:0]         ra4_q;
  logic [16:0]        f5_q;
  logic               ln2_q, ln3_q, ln4_q, ln5_q;
  logic signed [16:0] ts2_q, ts3_q, ts4_q, ts5_q, ts6_q;
  logic signed [35:0] lin6_q;

  logic [14:0] dabs;
  logic [50:0] qa_prod;
  logic [46:0] f_prod;
  logic [34:0] lin_mag;

  assign dabs    = dh1_q[15] ? 15'(-dh1_q) : 15'(dh1_q);
  assign qa_prod = 51'(a2_q) * 51'(stc_pkg::RCP100_A);
  assign f_prod  = (47'({ra4_q, 16'b0}) + 47'd50) * 47'(stc_pkg::RCP100_B);
  assign lin_mag = {qa5_q, 16'b0} + 35'(f5_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q   <= 25'(coef_q.linear) * 25'(dabs);
      ln2_q  <= dh1_q[15];
      ts2_q  <= ts1_q;

      qa3_q  <= qa_prod[50:32];
      a3_q   <= a2_q;
      ln3_q  <= ln2_q;
      ts3_q  <= ts2_q;

      ra4_q  <= 7'(a3_q - 25'(qa3_q) * 25'd100);
      qa4_q  <= qa3_q;
      ln4_q  <= ln3_q;
      ts4_q  <= ts3_q;

      f5_q   <= f_prod[46:30];
      qa5_q  <= qa4_q;
      ln5_q  <= ln4_q;
      ts5_q  <= ts4_q;

      lin6_q <= ln5_q ? -$signed({1'b0, lin_mag}) : $signed({1'b0, lin_mag});
      ts6_q  <= ts5_q;
    end
  end

  // ---------------- exp and log terms ----------------
  logic [41:0]        ex;
  logic signed [39:0] t67;

  stc_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en),
    .ta_i   (ta1_q),
    .coef_i (coef_q),
    .ex_o   (ex)
  );

  stc_log u_log (
    .clk_i  (clk_i),
    .en_i   (en),
    .dh_i   (dh1_q),
    .coef_i (coef_q),
    .t67_o  (t67)
  );

  // ---------------- accumulate ts*2^16 - td ----------------
  logic signed [45:0] w1_q;
  logic signed [45:0] w1d_q [0:D1-1];
  logic signed [45:0] w2_q;
  logic signed [45:0] w2d_q [0:D2-1];
  logic signed [45:0] v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q     <= (46'(ts6_q) <<< stc_pkg::FRAC_BITS) - 46'(lin6_q);
      w1d_q[0] <= w1_q;
      for (int i = 1; i < D1; i++) w1d_q[i] <= w1d_q[i-1];
      w2_q     <= w1d_q[D1-1] - 46'(t67);
      w2d_q[0] <= w2_q;
      for (int i = 1; i < D2; i++) w2d_q[i] <= w2d_q[i-1];
      v_q      <= w2d_q[D2-1] - $signed({4'b0, ex});
    end
  end

  // ---------------- round to hundredths, clip to 24 bits ----------------
  logic [45:0]        vmag;
  logic [29:0]        rq;
  logic signed [23:0] res_d, res_q;
  logic               sat_d, sat_q;

  assign vmag = v_q[45] ? 46'(-v_q) : 46'(v_q);
  assign rq   = 30'((vmag + 46'd32768) >> stc_pkg::FRAC_BITS);

  always_comb begin
    sat_d = 1'b0;
    if (!v_q[45]) begin
      if (rq > 30'd8388607) begin
        res_d = 24'sh7FFFFF;
        sat_d = 1'b1;
      end else begin
        res_d = $signed(rq[23:0]);
      end
    end else begin
      if (rq > 30'd8388608) begin
        res_d = 24'sh800000;
        sat_d = 1'b1;
      end else begin
        res_d = 24'(-$signed({1'b0, rq}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o.valid          = vld_q[PIPE_DEPTH-1];
  assign res_o.corrected_temp = res_q;
  assign res_o.saturated      = sat_q;

endmodule

### rtl/stc_exp.sv
module stc_exp (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic signed [14:0] ta_i,
  input  stc_pkg::coef_t coef_i,
  output logic [41:0]   ex_o
);

  // argument magnitude a = rate * power * |ta|
  logic [19:0] k45_q;
  logic [14:0] tam1_q;
  logic        neg1_q;
  logic [34:0] a2_q;
  logic        neg2_q;
  logic [27:0] a3_q;
  logic [11:0] q3_q;
  logic        big3_q, neg3_q;
  logic [16:0] r4_q;
  logic [11:0] q4_q;
  logic        big4_q, neg4_q;
  logic [9:0]  f5_q;
  logic [11:0] q5_q;
  logic        big5_q, neg5_q;
  logic [20:0] x6_q;
  logic        neg6_q;
  logic [20:0] x7_q;
  logic [4:0]  n7_q;
  logic        neg7_q;
  logic signed [15:0] r8_q;
  logic signed [5:0]  n8_q;

  logic [56:0] q3_prod;
  logic [52:0] f5_prod;
  logic [25:0] f5_num;
  logic [42:0] n7_prod;
  logic [20:0] r8_mag;

  assign q3_prod = 57'(a2_q[27:0]) * 57'(stc_pkg::RCP78125_A);
  assign f5_num  = {r4_q, 9'b0} + 26'd39062;
  assign f5_prod = 53'(f5_num) * 53'(stc_pkg::RCP78125_B);
  assign n7_prod = 43'(x6_q + 21'd22713) * 43'(stc_pkg::RCP_LN2);
  // remainder after range reduction, two's complement, within +-ln2/2
  assign r8_mag  = x7_q - 21'(n7_q * 21'(stc_pkg::LN2_Q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k45_q  <= 20'(coef_i.exp_rate) * 20'(coef_i.exp_power);
      tam1_q <= ta_i[14] ? 15'(-ta_i) : 15'(ta_i);
      neg1_q <= ta_i[14];

      a2_q   <= 35'(k45_q) * 35'(tam1_q);
      neg2_q <= neg1_q;

      // an argument of 18 or more clamps to 18
      big3_q <= (a2_q >= 35'd180000000);
      q3_q   <= q3_prod[56:45];
      a3_q   <= a2_q[27:0];
      neg3_q <= neg2_q;

      r4_q   <= 17'(a3_q - 28'(q3_q * 28'd78125));
      q4_q   <= q3_q;
      big4_q <= big3_q;
      neg4_q <= neg3_q;

      f5_q   <= f5_prod[52:43];
      q5_q   <= q4_q;
      big5_q <= big4_q;
      neg5_q <= neg4_q;

      x6_q   <= big5_q ? 21'd1179648 : ({q5_q, 9'b0} + 21'(f5_q));
      neg6_q <= neg5_q;

      n7_q   <= n7_prod[41:37];
      x7_q   <= x6_q;
      neg7_q <= neg6_q;

      r8_q   <= neg7_q ? -$signed(r8_mag[15:0]) : $signed(r8_mag[15:0]);
      n8_q   <= neg7_q ? -$signed({1'b0, n7_q}) : $signed({1'b0, n7_q});
    end
  end

  // Taylor series of exp(r), Horner form, two stages per term
  logic signed [34:0] prod_q [0:7];
  logic signed [15:0] ra_q   [0:7];
  logic signed [15:0] rb_q   [0:7];
  logic signed [5:0]  na_q   [0:7];
  logic signed [5:0]  nb_q   [0:7];
  logic signed [18:0] p_q    [0:7];

  for (genvar j = 0; j < 8; j++) begin : g_term
    localparam int          K    = 8 - j;
    localparam logic [18:0] HM   = stc_pkg::horner_mul(K);
    localparam int          HS   = stc_pkg::horner_shift(K);
    localparam logic [35:0] HALF = 36'(K) << (stc_pkg::FRAC_BITS - 1);

    logic signed [18:0] p_in;
    logic signed [15:0] r_in;
    logic signed [5:0]  n_in;
    logic [33:0]        mag;
    logic [19:0]        t;
    logic [38:0]        tm;
    logic [17:0]        qt;

    if (j == 0) begin : g_first
      assign p_in = 19'sd65536;
      assign r_in = r8_q;
      assign n_in = n8_q;
    end else begin : g_next
      assign p_in = p_q[j-1];
      assign r_in = rb_q[j-1];
      assign n_in = nb_q[j-1];
    end

    assign mag = prod_q[j][34] ? 34'(-prod_q[j]) : 34'(prod_q[j]);
    assign t   = 20'((36'(mag) + HALF) >> stc_pkg::FRAC_BITS);
    assign tm  = 39'(t) * 39'(HM);
    assign qt  = 18'(tm >> HS);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[j] <= 35'(p_in) * 35'(r_in);
        ra_q[j]   <= r_in;
        na_q[j]   <= n_in;
        p_q[j]    <= 19'sd65536 + (prod_q[j][34] ? -$signed({1'b0, qt})
                                                 : $signed({1'b0, qt}));
        rb_q[j]   <= ra_q[j];
        nb_q[j]   <= na_q[j];
      end
    end
  end

  // scale by 2^n, gain, cap at 2^41
  logic [17:0]        base_q;
  logic signed [5:0]  nbs_q;
  logic [27:0]        m_q;
  logic signed [5:0]  nm_q;
  logic [41:0]        ex_q;

  logic [4:0]  rsh;
  logic [26:0] rnd;
  logic [53:0] up;

  assign rsh = 5'(-nb_q[7]);
  assign rnd = (27'(p_q[7][17:0]) + (27'd1 << (rsh - 5'd1))) >> rsh;
  assign up  = 54'(m_q) << nm_q[4:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= nb_q[7][5] ? rnd[17:0] : p_q[7][17:0];
      nbs_q  <= nb_q[7];
      m_q    <= 28'(coef_i.exp_gain) * 28'(base_q);
      nm_q   <= nbs_q;
      if (nm_q[5]) begin
        ex_q <= 42'(m_q);
      end else if (up > 54'(42'd1 << 41)) begin
        ex_q <= 42'd1 << 41;
      end else begin
        ex_q <= up[41:0];
      end
    end
  end

  assign ex_o = ex_q;

endmodule

### rtl/stc_log.sv
module stc_log (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] dh_i,
  input  stc_pkg::coef_t     coef_i,
  output logic signed [39:0] t67_o
);

  typedef struct packed {
    logic               near;
    logic               neg;
    logic signed [15:0] dh;
    logic [3:0]         e;
    logic signed [20:0] k7t;
  } ctx_t;

  logic [14:0] adh;
  logic [3:0]  msb;
  logic [10:0] k7mag;
  logic [54:0] k7prod;

  assign adh    = dh_i[15] ? 15'(-dh_i) : 15'(dh_i);
  assign k7mag  = coef_i.log_offset[10] ? 11'(-coef_i.log_offset) : 11'(coef_i.log_offset);
  assign k7prod = 55'({k7mag, 16'b0} + 27'd50) * 55'(stc_pkg::RCP100_C);

  always_comb begin
    msb = 4'd0;
    for (int b = 0; b < 15; b++) begin
      if (adh[b]) msb = 4'(b);
    end
  end

  ctx_t        ctx_q  [0:16];
  logic [16:0] y_q    [0:16];
  logic [15:0] frac_q [0:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0].near <= (adh < 15'd100);
      ctx_q[0].neg  <= dh_i[15];
      ctx_q[0].dh   <= dh_i;
      ctx_q[0].e    <= msb;
      ctx_q[0].k7t  <= coef_i.log_offset[10] ? -$signed({1'b0, k7prod[53:34]})
                                             : $signed({1'b0, k7prod[53:34]});
      y_q[0]        <= 17'((31'(adh) << 16) >> msb);
      frac_q[0]     <= '0;
    end
  end

  // log2 fraction, one bit per stage by squaring the mantissa
  for (genvar i = 1; i <= 16; i++) begin : g_sq
    logic [33:0] sq;
    logic [17:0] t;

    assign sq = 34'(y_q[i-1]) * 34'(y_q[i-1]);
    assign t  = sq[33:16];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[i]  <= ctx_q[i-1];
        y_q[i]    <= t[17] ? t[17:1] : t[16:0];
        frac_q[i] <= {frac_q[i-1][14:0], t[17]};
      end
    end
  end

  ctx_t               c18_q, c19_q, c20_q;
  logic [48:0]        lp_q;
  logic signed [21:0] lg_q;
  logic signed [32:0] g_q;
  logic signed [39:0] t67_q;

  logic [19:0]        lg10;
  logic signed [39:0] tmul;
  logic signed [39:0] near_v;

  assign lg10   = 20'((lp_q + 49'(64'd1 << 29)) >> 30);
  assign tmul   = 40'(g_q) * 40'sd100;
  assign near_v = 40'(c20_q.dh) <<< stc_pkg::FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lp_q  <= 49'({ctx_q[16].e, frac_q[16]}) * 49'(stc_pkg::LOG10_2_Q30);
      c18_q <= ctx_q[16];

      // hundredths to degrees: minus two
      lg_q  <= $signed({2'b0, lg10}) - 22'sd131072 + 22'(c18_q.k7t);
      c19_q <= c18_q;

      g_q   <= 33'(coef_i.log_gain) * 33'(lg_q);
      c20_q <= c19_q;

      if (c20_q.near) begin
        if (coef_i.log_gain > 11'sd0)      t67_q <= near_v;
        else if (coef_i.log_gain < 11'sd0) t67_q <= -near_v;
        else                               t67_q <= '0;
      end else begin
        t67_q <= c20_q.neg ? -tmul : tmul;
      end
    end
  end

  assign t67_o = t67_q;

endmodule

### rtl/stc_checker.sv
module stc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] corrected_temp,
  input logic        saturated
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(corrected_temp) && $stable(saturated))
    else $error("result changed while stalled");

  // clipping only ever lands on the range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> (corrected_temp == 24'h7FFFFF || corrected_temp == 24'h800000))
    else $error("saturated flag without a limit value");

  // a stalled output freezes the pipe, so no request is taken
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output stalled");

  // with the output free the pipe always moves
  a_free_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

endmodule

bind sky_temperature_correction stc_checker u_stc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready       (req_i.ready),
  .out_valid      (res_o.valid),
  .out_ready      (res_o.ready),
  .corrected_temp (res_o.corrected_temp),
  .saturated      (res_o.saturated)
);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no request or result moving before the run is called hung
  localparam int STALL_LIMIT = 5000;
  localparam int PIPE_DRAIN  = 40;
  localparam int NUM_COEFS   = 7;

  typedef enum logic [1:0] { ROW_CFG, ROW_REQ, ROW_CHK } row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [stc_pkg::CFG_IDX_W-1:0] idx;
    int                            a;    // sky temp, or register value
    int                            b;    // ambient temp
    int                            want;
    bit                            want_sat;
  } row_t;

  typedef struct {
    logic signed [23:0] corrected;
    logic               sat;
  } corr_t;

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  stc_in_if  req ();
  stc_out_if res ();

  sky_temperature_correction dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the coefficients, updated on every register write
  stc_pkg::coef_t coefs;
  corr_t pending_q[$];
  int    err_cnt;
  int    src_idle;    // percent of cycles the sender sits out
  int    snk_stall;   // percent of cycles the receiver holds off
  logic  hold_res;    // long receiver hold-off, driven by its own process

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Correction math in fixed point, hundredths of a degree with Q.16 fraction
  // ---------------------------------------------------------------------------
  function automatic longint div_rnd(longint n, longint d);
    longint u;
    longint q;
    u = (n < 0) ? -n : n;
    q = (u + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint exp_fix(longint x);
    longint one;
    longint lim;
    longint ln2q;
    longint n;
    longint r;
    longint p;
    longint unsigned u;
    int s;
    one  = longint'(1) << stc_pkg::FRAC_BITS;
    lim  = 18 * one;
    ln2q = div_rnd(stc_pkg::LN2_Q30, longint'(1) << (30 - stc_pkg::FRAC_BITS));
    if (x > lim) x = lim;
    if (x < -lim) x = -lim;
    n = div_rnd(x, ln2q);
    r = x - n * ln2q;
    p = one;
    for (int k = 8; k >= 1; k--) p = one + div_rnd(p * r, k * one);
    if (n >= 0) return p << n;
    s = int'(-n);
    u = longint'(p);
    return longint'((u + (longint'(1) << (s - 1))) >> s);
  endfunction

  // log10 of an integer magnitude, Q.16
  function automatic longint log10_fix(longint m);
    longint unsigned one;
    longint unsigned y;
    longint unsigned frac;
    int e;
    one  = longint'(1) << stc_pkg::FRAC_BITS;
    frac = 0;
    e    = 0;
    while (e < 63 && (m >> (e + 1)) != 0) e++;
    y = (longint'(m) << stc_pkg::FRAC_BITS) >> e;
    for (int i = 1; i <= stc_pkg::FRAC_BITS; i++) begin
      y = (y * y) >> stc_pkg::FRAC_BITS;
      if (y >= 2 * one) begin
        y = y >> 1;
        frac |= longint'(1) << (stc_pkg::FRAC_BITS - i);
      end
    end
    return div_rnd(longint'((longint'(e) << stc_pkg::FRAC_BITS) + frac)
                   * stc_pkg::LOG10_2_Q30, longint'(1) << 30);
  endfunction

  function automatic corr_t correct_sky(logic signed [16:0] sky, logic signed [14:0] amb);
    longint one;
    longint ts;
    longint ta;
    longint dh;
    longint adh;
    longint lin;
    longint ex;
    longint t67;
    longint td;
    longint r;
    longint xq;
    longint lg;
    longint k6;
    corr_t  o;
    one = longint'(1) << stc_pkg::FRAC_BITS;
    ts  = longint'(sky);
    ta  = longint'(amb);
    k6  = longint'($signed(coefs.log_gain));
    dh  = ta - 10 * longint'($signed(coefs.offset));
    adh = (dh < 0) ? -dh : dh;
    lin = div_rnd(longint'(coefs.linear) * dh * one, 100);
    ex  = 0;
    if (coefs.exp_gain != 0) begin
      xq = div_rnd(longint'(coefs.exp_rate) * longint'(coefs.exp_power) * ta * one,
                   10000000);
      ex = longint'(coefs.exp_gain) * exp_fix(xq);
      if (ex > (longint'(33554432) * one)) ex = longint'(33554432) * one;
    end
    // near region follows only the sign of the log gain
    if (adh < 100) begin
      t67 = ((k6 < 0) ? -1 : (k6 > 0) ? 1 : 0) * dh * one;
    end else begin
      lg  = log10_fix(adh) - 2 * one
          + div_rnd(longint'($signed(coefs.log_offset)) * one, 100);
      t67 = k6 * ((dh < 0) ? -1 : 1) * lg * 100;
    end
    td    = lin + ex + t67;
    r     = div_rnd(ts * one - td, one);
    o.sat = 1'b0;
    if (r > 8388607) begin
      r = 8388607;
      o.sat = 1'b1;
    end
    if (r < -8388608) begin
      r = -8388608;
      o.sat = 1'b1;
    end
    o.corrected = r[23:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes (pipe must be empty)
  // ---------------------------------------------------------------------------
  task automatic write_coef(logic [stc_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[stc_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      stc_pkg::REG_LINEAR:     coefs.linear     = val[9:0];
      stc_pkg::REG_OFFSET:     coefs.offset     = val[10:0];
      stc_pkg::REG_EXP_GAIN:   coefs.exp_gain   = val[9:0];
      stc_pkg::REG_EXP_RATE:   coefs.exp_rate   = val[9:0];
      stc_pkg::REG_EXP_POWER:  coefs.exp_power  = val[9:0];
      stc_pkg::REG_LOG_GAIN:   coefs.log_gain   = val[10:0];
      stc_pkg::REG_LOG_OFFSET: coefs.log_offset = val[10:0];
      default: ;   // unmapped index: the block ignores it
    endcase
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sender pauses until every outstanding result is back
  task automatic drain_pipe();
    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // One request: random idle gaps first, then hold until accepted
  // ---------------------------------------------------------------------------
  task automatic send_req(logic signed [16:0] sky, logic signed [14:0] amb);
    while ($urandom_range(99) < src_idle) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.sky_temp     <= sky;
    req.ambient_temp <= amb;
    do @(posedge clk_i); while (!req.ready);
    pending_q.push_back(correct_sky(sky, amb));
  endtask

  // Random register value: extremes half the time
  function automatic int pick_coef(logic [stc_pkg::CFG_IDX_W-1:0] idx);
    bit signd;
    int v;
    signd = (idx == stc_pkg::REG_OFFSET) || (idx == stc_pkg::REG_LOG_GAIN)
         || (idx == stc_pkg::REG_LOG_OFFSET);
    case ($urandom_range(7))
      0: v = signd ? -1024 : 0;
      1: v = signd ? 1023 : 1023;
      2: v = signd ? -1000 : 1000;
      3: v = signd ? 1000 : 0;
      default: v = signd ? $urandom_range(2047) - 1024 : $urandom_range(1023);
    endcase
    // keep the exponential term modest most of the time so results vary
    if (idx == stc_pkg::REG_EXP_RATE && $urandom_range(3) != 0) v = $urandom_range(200);
    return v;
  endfunction

  task automatic random_coefs();
    logic [stc_pkg::CFG_IDX_W-1:0] idx;
    for (int i = 0; i < NUM_COEFS; i++) begin
      idx = i[stc_pkg::CFG_IDX_W-1:0];
      write_coef(idx, pick_coef(idx));
    end
    end_writes();
  endtask

  task automatic random_reqs(int n);
    logic signed [16:0] sky;
    logic signed [14:0] amb;
    for (int i = 0; i < n; i++) begin
      // mostly the sensor's real range, sometimes any bit pattern
      if ($urandom_range(4) == 0) begin
        sky = 17'($urandom);
        amb = 15'($urandom);
      end else begin
        sky = 17'($urandom_range(45000) - 7000);
        amb = 15'($urandom_range(16500) - 4000);
      end
      send_req(sky, amb);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed-in results only where the terms are off or the result clips.
  // ---------------------------------------------------------------------------
  row_t dir_tab[] = '{
    '{ROW_CHK, 0, 0,      0,      0, 0},      // default coefficients
    '{ROW_CHK, 0, 38000,  12500,  0, 0},
    '{ROW_CFG, stc_pkg::REG_LINEAR,   0, 0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_EXP_GAIN, 0, 0, 0, 0},
    // all terms off: result is the sky reading itself
    '{ROW_REQ, 0, 0,      0,      0,      0},
    '{ROW_REQ, 0, 38000,  12500,  38000,  0},
    '{ROW_REQ, 0, -7000,  -4000,  -7000,  0},
    '{ROW_REQ, 0, 65535,  -16384, 65535,  0},
    '{ROW_REQ, 0, -65536, 16383,  -65536, 0},
    '{ROW_CFG, stc_pkg::REG_LOG_GAIN,   1000,  0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_LOG_OFFSET, -1000, 0, 0, 0},
    // near region edges and log region extremes
    '{ROW_CHK, 0, 100, 50,     0, 0},
    '{ROW_CHK, 0, 0,   -99,    0, 0},
    '{ROW_CHK, 0, 0,   100,    0, 0},
    '{ROW_CHK, 0, 0,   -100,   0, 0},
    '{ROW_CHK, 0, 0,   16383,  0, 0},
    '{ROW_CHK, 0, 0,   -16384, 0, 0},
    '{ROW_CFG, stc_pkg::REG_LOG_GAIN,  -1024, 0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_OFFSET,    -1024, 0, 0, 0},
    '{ROW_CHK, 0, 0,   16383,  0, 0},
    '{ROW_CHK, 0, 0,   -16384, 0, 0},
    '{ROW_CFG, stc_pkg::REG_LOG_GAIN,  0,    0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_OFFSET,    1023, 0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_EXP_GAIN,  1023, 0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_EXP_RATE,  1023, 0, 0, 0},
    '{ROW_CFG, stc_pkg::REG_EXP_POWER, 1023, 0, 0, 0},
    '{ROW_CFG, 3'd7,                   5,    0, 0, 0},   // unmapped, ignored
    // exponent overflow: term hits its cap, result clips low
    '{ROW_REQ, 0, 0,     16383,  -8388608, 1},
    '{ROW_CHK, 0, 1234,  -16384, 0,        0},
    '{ROW_CHK, 0, -7000, 200,    0,        0}
  };

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    corr_t exp_r;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with none pending: %0d sat %0b", $time,
                 res.corrected_temp, res.saturated);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (res.corrected_temp !== exp_r.corrected) begin
          $display("%0t: corrected_temp expected %0d got %0d", $time,
                   exp_r.corrected, res.corrected_temp);
          err_cnt++;
        end
        if (res.saturated !== exp_r.sat) begin
          $display("%0t: saturated expected %0b got %0b", $time, exp_r.sat,
                   res.saturated);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    res.ready <= !hold_res && ($urandom_range(99) >= snk_stall);
  end

  // Watchdog: no request and no result moving for too long
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int idle_pct[4];
    int stall_pct[4];
    corr_t typed;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    req.valid        = 1'b0;
    req.sky_temp     = '0;
    req.ambient_temp = '0;
    hold_res         = 1'b0;
    err_cnt          = 0;
    src_idle         = 0;
    snk_stall        = 0;
    coefs            = stc_pkg::COEF_RESET;
    idle_pct  = '{0, 80, 0, 19};
    stall_pct = '{0, 0, 80, 19};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (pending_q.size() != 0) drain_pipe();
        write_coef(dir_tab[i].idx, dir_tab[i].a);
        if (i + 1 >= dir_tab.size() || dir_tab[i + 1].kind != ROW_CFG) end_writes();
      end else begin
        send_req(17'(dir_tab[i].a), 15'(dir_tab[i].b));
        if (dir_tab[i].kind == ROW_REQ) begin
          // typed value replaces the predicted one
          typed.corrected = 24'(dir_tab[i].want);
          typed.sat       = dir_tab[i].want_sat;
          pending_q[pending_q.size() - 1] = typed;
        end
      end
    end
    drain_pipe();

    // random part: four idling phases, several coefficient sets each
    for (int ph = 0; ph < 4; ph++) begin
      src_idle  = idle_pct[ph];
      snk_stall = stall_pct[ph];
      for (int set = 0; set < 4; set++) begin
        random_coefs();
        if (ph == 0 && set == 1) begin
          // long receiver hold-off while requests keep coming: pipe fills
          fork
            begin
              hold_res <= 1'b1;
              repeat (300) @(posedge clk_i);
              hold_res <= 1'b0;
            end
          join_none
        end
        random_reqs(108);
        drain_pipe();
      end
    end

    // wind down
    snk_stall = 0;
    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/stc_pkg.sv
rtl/stc_if.sv
rtl/stc_exp.sv
rtl/stc_log.sv
rtl/sky_temperature_correction.sv
rtl/stc_checker.sv
test/tb.sv
